// ===== design/hlmdu_pkg.sv =====
// Package with operation codes, lane count and helper types for the HI/LO multiply/divide unit.
package hlmdu_pkg;

  typedef enum logic [3:0] {
    OP_MULT    = 4'd0,
    OP_MULTU   = 4'd1,
    OP_DIV     = 4'd2,
    OP_DIVU    = 4'd3,
    OP_PMULTH  = 4'd4,
    OP_PMULTW  = 4'd5,
    OP_PMULTUW = 4'd6,
    OP_PDIVW   = 4'd7,
    OP_PDIVUW  = 4'd8,
    OP_PDIVBW  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned DIV_STEPS   = 32;
  localparam logic [31:0] WORD_NEG_LIMIT = 32'h8000_0000;

  // Per-lane divide request.
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        zero;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic [63:0] sext32(input logic [31:0] v);
    sext32 = {{32{v[31]}}, v};
  endfunction

endpackage

// ===== design/hi_lo_multiply_divide_unit.sv =====
// Top level of the HI/LO multiply/divide unit: lanes, merge, LO/HI state and handshakes.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | action, rs_low/high, rt_low/high
//   out_    | output    | out_valid / out_ready | rd_write_mask, rd_*, lo_*, hi_*
//
// A multiply passes through the ST_MUL and ST_DIV states before its result is registered; a divide
// waits in ST_DIV for the four 32-step iterative divider lanes working side by side.
// One transaction is in flight at a time; in_ready is high only while idle.
// The result register holds until out_ready; the next transaction is taken once it
// drains. Reset (synchronous, rst_n low) clears LO, HI and the control state.
module hi_lo_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_action,
  input  logic [63:0] in_rs_low,
  input  logic [63:0] in_rs_high,
  input  logic [63:0] in_rt_low,
  input  logic [63:0] in_rt_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_rd_write_mask,
  output logic [63:0] out_rd_low,
  output logic [63:0] out_rd_high,
  output logic [63:0] out_lo_low,
  output logic [63:0] out_lo_high,
  output logic [63:0] out_hi_low,
  output logic [63:0] out_hi_high
);

  localparam int unsigned NL = hlmdu_pkg::NUM_LANES;

  hlmdu_pkg::state_t state_r, state_nxt;
  logic [3:0]   op_r;
  logic [127:0] rs_r, rt_r;
  logic [63:0]  lo_r [2];
  logic [63:0]  hi_r [2];
  logic [63:0]  lo_nxt [2];
  logic [63:0]  hi_nxt [2];
  logic [1:0]   mask_nxt;
  logic [63:0]  rd_nxt [2];
  logic         accept, mul_en, div_start, state_we;

  hlmdu_pkg::div_req_t dreq [NL];
  hlmdu_pkg::div_rsp_t drsp [NL];
  logic [63:0] mprod [2];
  logic [31:0] mph0 [4];
  logic [31:0] mph1 [4];
  logic        sgn_mul, sgn_div, bw, is_div;
  logic [31:0] bw_div;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == hlmdu_pkg::ST_IDLE);
  assign out_valid = (state_r == hlmdu_pkg::ST_DONE);

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_action;
      rs_r <= {in_rs_high, in_rs_low};
      rt_r <= {in_rt_high, in_rt_low};
    end
  end

  assign sgn_mul = (op_r == 4'(hlmdu_pkg::OP_MULT)) || (op_r == 4'(hlmdu_pkg::OP_PMULTW));
  assign bw      = (op_r == 4'(hlmdu_pkg::OP_PDIVBW));
  assign sgn_div = (op_r == 4'(hlmdu_pkg::OP_DIV)) || (op_r == 4'(hlmdu_pkg::OP_PDIVW)) || bw;
  assign bw_div  = {{16{rt_r[15]}}, rt_r[15:0]};
  assign is_div  = op_r inside {hlmdu_pkg::OP_DIV, hlmdu_pkg::OP_DIVU, hlmdu_pkg::OP_PDIVW,
                                hlmdu_pkg::OP_PDIVUW, hlmdu_pkg::OP_PDIVBW};

  // Multiplier lanes: lanes 0 and 1 use words 0 and 2; all four give halfword products.
  for (genvar k = 0; k < 4; k++) begin : g_mul
    localparam int WI = (k < 2) ? 2 * k : 2 * (k - 2) + 1;
    logic [63:0] p;
    hlmdu_mul_lane u_mul (
      .clk (clk), .en (mul_en), .sgn (sgn_mul),
      .a (rs_r[32*WI +: 32]),
      .b (rt_r[32*WI +: 32]),
      .prod (p), .ph0 (mph0[k]), .ph1 (mph1[k])
    );
    if (k < 2) begin : g_p
      assign mprod[k] = p;
    end
  end

  // Divider lanes: PDIVBW uses all four words; other divides use words 0 and 2.
  for (genvar k = 0; k < NL; k++) begin : g_div
    always_comb begin
      dreq[k].start    = div_start;
      dreq[k].sgn      = sgn_div;
      dreq[k].dividend = bw ? rs_r[32*k +: 32] : rs_r[64*(k/2) +: 32];
      dreq[k].divisor  = bw ? bw_div : rt_r[64*(k/2) +: 32];
    end
    hlmdu_div_lane u_div (.clk (clk), .rst_n (rst_n), .req (dreq[k]), .rsp (drsp[k]));
  end

  // Merge stage.
  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    rd_nxt[0] = 64'd0;
    rd_nxt[1] = 64'd0;
    mask_nxt = 2'd0;
    case (op_r) inside
      hlmdu_pkg::OP_MULT, hlmdu_pkg::OP_MULTU: begin
        lo_nxt[0] = hlmdu_pkg::sext32(mprod[0][31:0]);
        hi_nxt[0] = hlmdu_pkg::sext32(mprod[0][63:32]);
        rd_nxt[0] = lo_nxt[0];
        mask_nxt  = 2'd1;
      end
      hlmdu_pkg::OP_PMULTW, hlmdu_pkg::OP_PMULTUW: begin
        for (int k = 0; k < 2; k++) begin
          lo_nxt[k] = hlmdu_pkg::sext32(mprod[k][31:0]);
          hi_nxt[k] = hlmdu_pkg::sext32(mprod[k][63:32]);
          rd_nxt[k] = mprod[k];
        end
        mask_nxt = 2'd3;
      end
      hlmdu_pkg::OP_PMULTH: begin
        // Halfword k of rs: lane 0 holds hw 0,1; lane 2 hw 2,3; lane 1 hw 4,5; lane 3 hw 6,7.
        rd_nxt[0] = {mph0[2], mph0[0]};
        rd_nxt[1] = {mph0[3], mph0[1]};
        lo_nxt[0] = {mph1[0], mph0[0]};
        lo_nxt[1] = {mph1[1], mph0[1]};
        hi_nxt[0] = {mph1[2], mph0[2]};
        hi_nxt[1] = {mph1[3], mph0[3]};
        mask_nxt  = 2'd3;
      end
      hlmdu_pkg::OP_DIV, hlmdu_pkg::OP_DIVU: begin
        if (!drsp[0].zero) begin
          lo_nxt[0] = hlmdu_pkg::sext32(drsp[0].quot);
          hi_nxt[0] = hlmdu_pkg::sext32(drsp[0].rem);
        end
      end
      hlmdu_pkg::OP_PDIVW, hlmdu_pkg::OP_PDIVUW: begin
        for (int k = 0; k < 2; k++) begin
          if (!drsp[2*k].zero) begin
            lo_nxt[k] = hlmdu_pkg::sext32(drsp[2*k].quot);
            hi_nxt[k] = hlmdu_pkg::sext32(drsp[2*k].rem);
          end
        end
      end
      hlmdu_pkg::OP_PDIVBW: begin
        if (!drsp[0].zero) begin
          lo_nxt[0] = {drsp[1].quot, drsp[0].quot};
          lo_nxt[1] = {drsp[3].quot, drsp[2].quot};
          hi_nxt[0] = {drsp[1].rem, drsp[0].rem};
          hi_nxt[1] = {drsp[3].rem, drsp[2].rem};
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    mul_en    = 1'b0;
    div_start = 1'b0;
    state_we  = 1'b0;
    unique case (state_r)
      hlmdu_pkg::ST_IDLE: begin
        if (accept) state_nxt = hlmdu_pkg::ST_MUL;
      end
      hlmdu_pkg::ST_MUL: begin
        if (is_div) begin
          div_start = 1'b1;
          state_nxt = hlmdu_pkg::ST_DIV;
        end else begin
          mul_en    = 1'b1;
          state_nxt = hlmdu_pkg::ST_DIV;
        end
      end
      hlmdu_pkg::ST_DIV: begin
        // Multiplies pass straight through; divides wait for the lanes.
        if (drsp[0].done || !is_div) begin
          state_we  = 1'b1;
          state_nxt = hlmdu_pkg::ST_DONE;
        end
      end
      hlmdu_pkg::ST_DONE: begin
        if (out_ready) state_nxt = hlmdu_pkg::ST_IDLE;
      end
      default: state_nxt = hlmdu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hlmdu_pkg::ST_IDLE;
      lo_r[0] <= 64'd0;
      lo_r[1] <= 64'd0;
      hi_r[0] <= 64'd0;
      hi_r[1] <= 64'd0;
    end else begin
      state_r <= state_nxt;
      if (state_we) begin
        lo_r <= lo_nxt;
        hi_r <= hi_nxt;
        out_rd_write_mask <= mask_nxt;
        out_rd_low  <= rd_nxt[0];
        out_rd_high <= rd_nxt[1];
      end
    end
  end

  assign out_lo_low  = lo_r[0];
  assign out_lo_high = lo_r[1];
  assign out_hi_low  = hi_r[0];
  assign out_hi_high = hi_r[1];

  // A result is shown only after a transaction was taken and worked on.
  a_done_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == hlmdu_pkg::ST_DIV)
    else $error("result raised without passing the work state");

  // LO and HI change only when a result is being committed.
  a_lo_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(state_we) && $past(rst_n) |-> $stable(out_lo_low) && $stable(out_hi_high))
    else $error("LO/HI changed outside commit");

  // Never ready for input while a result is waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

endmodule

// ===== design/hlmdu_div_lane.sv =====
// One iterative restoring divider lane, one quotient bit per cycle.
module hlmdu_div_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  hlmdu_pkg::div_req_t req,
  output hlmdu_pkg::div_rsp_t rsp
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] a_r, a_nxt;      // shifts in dividend, collects quotient
  logic [31:0] b_r, b_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic        nq_r, nq_nxt, nr_r, nr_nxt, zero_r, zero_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    nr_nxt   = nr_r;
    zero_nxt = zero_r;
    shifted  = {rem_r[31:0], a_r[31]};
    trial    = shifted - {1'b0, b_r};
    if (req.start) begin
      nr_nxt   = req.sgn && req.dividend[31];
      nq_nxt   = req.sgn && (req.dividend[31] != req.divisor[31]);
      a_nxt    = (req.sgn && req.dividend[31]) ? 32'd0 - req.dividend : req.dividend;
      b_nxt    = (req.sgn && req.divisor[31]) ? 32'd0 - req.divisor : req.divisor;
      zero_nxt = (req.divisor == 32'd0);
      rem_nxt  = 33'd0;
      cnt_nxt  = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        a_nxt   = {a_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        a_nxt   = {a_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(hlmdu_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    rem_r  <= rem_nxt;
    nq_r   <= nq_nxt;
    nr_r   <= nr_nxt;
    zero_r <= zero_nxt;
  end

  // Unsigned magnitudes wrap correctly for minimum over minus one.
  assign rsp.done = done_r;
  assign rsp.zero = zero_r;
  assign rsp.quot = nq_r ? 32'd0 - a_r : a_r;
  assign rsp.rem  = nr_r ? 32'd0 - rem_r[31:0] : rem_r[31:0];

endmodule

// ===== design/hlmdu_mul_lane.sv =====
// One registered 33x33 signed multiplier lane, also holding two 16x16 products.
module hlmdu_mul_lane (
  input  logic        clk,
  input  logic        en,
  input  logic        sgn,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod,
  output logic [31:0] ph0,
  output logic [31:0] ph1
);

  logic [63:0] prod_r;
  logic [31:0] ph0_r, ph1_r;
  logic signed [32:0] ea, eb;
  logic signed [65:0] full;

  always_comb begin
    ea   = $signed({sgn & a[31], a});
    eb   = $signed({sgn & b[31], b});
    full = ea * eb;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= full[63:0];
      ph0_r  <= 32'($signed(a[15:0]) * $signed(b[15:0]));
      ph1_r  <= 32'($signed(a[31:16]) * $signed(b[31:16]));
    end
  end

  assign prod = prod_r;
  assign ph0  = ph0_r;
  assign ph1  = ph1_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the HI/LO multiply/divide unit with a driver, monitor and predictor.
module tb;

  // One operation as it travels through the input channel.
  typedef struct {
    logic [3:0]  action;
    logic [63:0] rs_lo, rs_hi, rt_lo, rt_hi;
  } mdu_op_t;

  // One result as it leaves the unit.
  typedef struct {
    logic [1:0]  mask;
    logic [63:0] rd_lo, rd_hi, lo_lo, lo_hi, hi_lo, hi_hi;
  } mdu_res_t;

  // The pause marker is an operation with this action code; the driver holds off on it.
  localparam logic [3:0] ACT_PAUSE = 4'hF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_action = '0;
  logic [63:0] in_rs_low = '0, in_rs_high = '0, in_rt_low = '0, in_rt_high = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_rd_write_mask;
  logic [63:0] out_rd_low, out_rd_high, out_lo_low, out_lo_high, out_hi_low, out_hi_high;

  hi_lo_multiply_divide_unit i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  mdu_op_t  pending_ops[$];
  mdu_res_t expected_results[$];
  logic [63:0] lo_model[2];
  logic [63:0] hi_model[2];
  int errors = 0;
  bit quiet = 0;   // no idling in the last part of the run

  function automatic logic [63:0] sx(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // Truncating divide; the remainder takes the dividend's sign. Divisor is nonzero.
  function automatic void div32(input logic [31:0] a, b, input bit sgn,
                                output logic [31:0] q, r);
    logic [31:0] ua, ub, uq, ur;
    bit na, nb;
    na = sgn && a[31];
    nb = sgn && b[31];
    ua = na ? -a : a;
    ub = nb ? -b : b;
    uq = ua / ub;
    ur = ua % ub;
    q = (na != nb) ? -uq : uq;
    r = na ? -ur : ur;
  endfunction

  function automatic logic [63:0] mul32(input logic [31:0] a, b, input bit sgn);
    if (sgn) return sx(a) * sx(b);
    return {32'd0, a} * {32'd0, b};
  endfunction

  // Applies one operation to the LO/HI copy and returns the result the unit must produce.
  function automatic mdu_res_t predict_hilo(input mdu_op_t op);
    mdu_res_t res;
    logic [63:0] rs[2], rt[2], rd[2], p;
    logic [31:0] q, r, b, ph[8];
    logic [15:0] ha, hb;
    rs[0] = op.rs_lo; rs[1] = op.rs_hi;
    rt[0] = op.rt_lo; rt[1] = op.rt_hi;
    rd[0] = '0; rd[1] = '0;
    res.mask = 2'd0;
    case (op.action) inside
      hlmdu_pkg::OP_MULT, hlmdu_pkg::OP_MULTU: begin
        p = mul32(rs[0][31:0], rt[0][31:0], op.action == hlmdu_pkg::OP_MULT);
        lo_model[0] = sx(p[31:0]);
        hi_model[0] = sx(p[63:32]);
        rd[0] = lo_model[0];
        res.mask = 2'd1;
      end
      hlmdu_pkg::OP_DIV, hlmdu_pkg::OP_DIVU: begin
        if (rt[0][31:0] != 32'd0) begin
          div32(rs[0][31:0], rt[0][31:0], op.action == hlmdu_pkg::OP_DIV, q, r);
          lo_model[0] = sx(q);
          hi_model[0] = sx(r);
        end
      end
      hlmdu_pkg::OP_PMULTH: begin
        for (int k = 0; k < 8; k++) begin
          ha = rs[k / 4][16 * (k % 4) +: 16];
          hb = rt[k / 4][16 * (k % 4) +: 16];
          ph[k] = {{16{ha[15]}}, ha} * {{16{hb[15]}}, hb};
        end
        rd[0] = {ph[2], ph[0]};
        rd[1] = {ph[6], ph[4]};
        lo_model[0] = {ph[1], ph[0]};
        lo_model[1] = {ph[5], ph[4]};
        hi_model[0] = {ph[3], ph[2]};
        hi_model[1] = {ph[7], ph[6]};
        res.mask = 2'd3;
      end
      hlmdu_pkg::OP_PMULTW, hlmdu_pkg::OP_PMULTUW: begin
        for (int k = 0; k < 2; k++) begin
          p = mul32(rs[k][31:0], rt[k][31:0], op.action == hlmdu_pkg::OP_PMULTW);
          lo_model[k] = sx(p[31:0]);
          hi_model[k] = sx(p[63:32]);
          rd[k] = p;
        end
        res.mask = 2'd3;
      end
      hlmdu_pkg::OP_PDIVW, hlmdu_pkg::OP_PDIVUW: begin
        for (int k = 0; k < 2; k++) begin
          if (rt[k][31:0] != 32'd0) begin
            div32(rs[k][31:0], rt[k][31:0], op.action == hlmdu_pkg::OP_PDIVW, q, r);
            lo_model[k] = sx(q);
            hi_model[k] = sx(r);
          end
        end
      end
      hlmdu_pkg::OP_PDIVBW: begin
        b = {{16{rt[0][15]}}, rt[0][15:0]};
        if (b != 32'd0) begin
          for (int k = 0; k < 4; k++) begin
            div32(rs[k / 2][32 * (k % 2) +: 32], b, 1'b1, q, r);
            lo_model[k / 2][32 * (k % 2) +: 32] = q;
            hi_model[k / 2][32 * (k % 2) +: 32] = r;
          end
        end
      end
      default: ;
    endcase
    res.rd_lo = res.mask[0] ? rd[0] : '0;
    res.rd_hi = res.mask[1] ? rd[1] : '0;
    res.lo_lo = lo_model[0];
    res.lo_hi = lo_model[1];
    res.hi_lo = hi_model[0];
    res.hi_hi = hi_model[1];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Operand words skewed toward corner values so divides hit zero, minimum and minus one.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return hlmdu_pkg::WORD_NEG_LIMIT;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  function automatic mdu_op_t make_op(input logic [3:0] act, input logic [63:0] a, b, c, d);
    mdu_op_t op;
    op.action = act;
    op.rs_lo = a; op.rs_hi = b; op.rt_lo = c; op.rt_hi = d;
    return op;
  endfunction

  // Driver: presents queued operations, idles in random bursts, honors pause markers.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        void'(pending_ops.pop_front());
      end
      if (in_valid && !in_ready) begin
        // Hold the transaction until it is accepted.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        mdu_op_t nxt;
        nxt = pending_ops[0];
        if (nxt.action == ACT_PAUSE) begin
          // Wait for the unit to drain before moving on.
          in_valid <= 1'b0;
          if (!(in_valid && in_ready) && expected_results.size() == 0) begin
            void'(pending_ops.pop_front());
          end
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 10);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_action <= nxt.action;
          in_rs_low <= nxt.rs_lo;
          in_rs_high <= nxt.rs_hi;
          in_rt_low <= nxt.rt_lo;
          in_rt_high <= nxt.rt_hi;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predictor hook: every accepted transaction produces exactly one expected result.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_results.push_back(predict_hilo(make_op(in_action, in_rs_low, in_rs_high,
                                                      in_rt_low, in_rt_high)));
    end
  end

  // Monitor: random backpressure on out_ready and field-by-field comparison.
  int stall = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none actual mask %0d",
                   $time, out_rd_write_mask);
          errors++;
        end else begin
          mdu_res_t e;
          e = expected_results.pop_front();
          if (out_rd_write_mask !== e.mask) begin
            $display("%0t: rd_write_mask expected %0d actual %0d", $time, e.mask,
                     out_rd_write_mask);
            errors++;
          end
          if (out_rd_low !== e.rd_lo) begin
            $display("%0t: rd_low expected %h actual %h", $time, e.rd_lo, out_rd_low);
            errors++;
          end
          if (out_rd_high !== e.rd_hi) begin
            $display("%0t: rd_high expected %h actual %h", $time, e.rd_hi, out_rd_high);
            errors++;
          end
          if (out_lo_low !== e.lo_lo) begin
            $display("%0t: lo_low expected %h actual %h", $time, e.lo_lo, out_lo_low);
            errors++;
          end
          if (out_lo_high !== e.lo_hi) begin
            $display("%0t: lo_high expected %h actual %h", $time, e.lo_hi, out_lo_high);
            errors++;
          end
          if (out_hi_low !== e.hi_lo) begin
            $display("%0t: hi_low expected %h actual %h", $time, e.hi_lo, out_hi_low);
            errors++;
          end
          if (out_hi_high !== e.hi_hi) begin
            $display("%0t: hi_high expected %h actual %h", $time, e.hi_hi, out_hi_high);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        stall <= $urandom_range(1, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed corners first, then random mixes, then a quiet tail.
  initial begin
    logic [3:0] act;
    lo_model[0] = '0; lo_model[1] = '0;
    hi_model[0] = '0; hi_model[1] = '0;
    // Every operation with all-ones operands.
    for (int a = 0; a <= 9; a++) begin
      pending_ops.push_back(make_op(4'(a), '1, '1, '1, '1));
    end
    // Minimum over minus one, scalar and lane-wise, and the halfword-divisor form.
    pending_ops.push_back(make_op(hlmdu_pkg::OP_DIV, 64'h8000_0000, '0, 64'hFFFF_FFFF, '0));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_PDIVW, 64'h8000_0000, 64'h8000_0000,
                                  64'hFFFF_FFFF, 64'hFFFF_FFFF));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_PDIVBW, {2{32'h8000_0000}},
                                  {2{32'h8000_0000}}, 64'hFFFF, '0));
    // Divide by zero must leave LO and HI alone after a MULT; a DIVU, MULTU and PMULTH follow.
    pending_ops.push_back(make_op(hlmdu_pkg::OP_MULT, 64'h1234_5678, '0, 64'h7FFF_FFFF, '0));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_DIVU, '1, '1, 64'hFFFF_FFFF_0000_0000, '1));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_PDIVUW, '1, '1, 64'h0, 64'h5));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_PDIVBW, '1, '1, 64'hFFFF_FFFF_FFFF_0000, '1));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_DIVU, 64'hFFFF_FFFF, '0, 64'h3, '0));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_MULTU, 64'hFFFF_FFFF, '0, 64'hFFFF_FFFF, '0));
    pending_ops.push_back(make_op(hlmdu_pkg::OP_PMULTH, {4{16'h8000}}, {4{16'h8000}},
                                  {4{16'h8000}}, {4{16'h7FFF}}));
    pending_ops.push_back(make_op(4'd10, '1, '1, '1, '1));
    pending_ops.push_back(make_op(4'd14, '0, '0, '0, '0));
    pending_ops.push_back(make_op(ACT_PAUSE, '0, '0, '0, '0));
    for (int i = 0; i < 400; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        act = 4'($urandom_range(10, 14));   // unused codes, kept rare
      end else begin
        act = 4'($urandom_range(0, 9));
      end
      if ($urandom_range(0, 2) == 0) begin
        pending_ops.push_back(make_op(act, rand64(), rand64(), rand64(), rand64()));
      end else begin
        pending_ops.push_back(make_op(act, {pick_word(), pick_word()},
                                      {pick_word(), pick_word()},
                                      {pick_word(), pick_word()},
                                      {pick_word(), pick_word()}));
      end
      if (i == 200) begin
        pending_ops.push_back(make_op(ACT_PAUSE, '0, '0, '0, '0));
      end
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_ops.size() < 40);
    quiet = 1;
    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: ends the run as failed; the limit covers about 430 transactions at worst many times over.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
